// ===== rtl/mlpq_pkg.sv =====
// Shared constants, codes and handshake structs for the multi-level process queue.
package mlpq_pkg;

  localparam int ENTRIES_PER_LEVEL = 64;
  localparam int LEVELS            = 5;

  localparam int IDX_W  = (ENTRIES_PER_LEVEL > 1) ? $clog2(ENTRIES_PER_LEVEL) : 1;
  localparam int CNT_W  = $clog2(ENTRIES_PER_LEVEL + 1);
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DEPTH  = LEVELS * ENTRIES_PER_LEVEL;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int OP_W     = 2;
  localparam int LSEL_W   = 3;
  localparam int PID_W    = 6;
  localparam int STAT_W   = 2;
  localparam int LCOUNT_W = 7;

  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_REM = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [PID_W-1:0]  proc_id;
    logic [LSEL_W-1:0] level_select;
    logic [OP_W-1:0]   op;
  } req_t;

  typedef struct packed {
    logic [LCOUNT_W-1:0] level_count;
    logic [STAT_W-1:0]   status;
    logic [PID_W-1:0]    result_id;
  } rsp_t;

endpackage

// ===== rtl/mlpq_engine.sv =====
// Sequencer, entry memory and occupancy counters that carry out one queue operation.
module mlpq_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  mlpq_pkg::req_t req,
  output logic          req_ready,
  output logic          rsp_valid,
  output mlpq_pkg::rsp_t rsp,
  input  logic          rsp_take
);
  import mlpq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_HEAD  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_SHIFT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]   op_r, op_nxt;
  logic [PID_W-1:0]  pid_r, pid_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic              lvl_ok_r, lvl_ok_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  ri_r, ri_nxt;
  logic              pv_r, pv_nxt;
  logic [CNT_W-1:0]  pidx_r, pidx_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  rsp_t              rsp_r, rsp_nxt;
  logic [CNT_W-1:0]  occ_r   [LEVELS];
  logic [CNT_W-1:0]  occ_nxt [LEVELS];

  logic [PID_W-1:0]  mem [DEPTH];
  logic [PID_W-1:0]  rd_q;
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] mem_ra, mem_wa;
  logic [PID_W-1:0]  mem_wd;

  logic [LVL_W-1:0]  in_lvl;
  logic              in_lvl_ok;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  wr_idx;
  logic              issue;

  assign in_lvl    = req.level_select[LVL_W-1:0];
  assign in_lvl_ok = (int'(req.level_select) < LEVELS);
  assign rd_addr   = base_r + ADDR_W'(ri_r[IDX_W-1:0]);
  assign wr_idx    = pidx_r - CNT_W'(1);
  assign issue     = (ri_r < n_r);

  assign req_ready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_DONE);
  assign rsp       = rsp_r;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    pid_nxt    = pid_r;
    lvl_nxt    = lvl_r;
    lvl_ok_nxt = lvl_ok_r;
    base_nxt   = base_r;
    n_nxt      = n_r;
    ri_nxt     = ri_r;
    pv_nxt     = pv_r;
    pidx_nxt   = pidx_r;
    hit_nxt    = hit_r;
    pos_nxt    = pos_r;
    rsp_nxt    = rsp_r;
    occ_nxt    = occ_r;
    mem_re     = 1'b0;
    mem_ra     = rd_addr;
    mem_we     = 1'b0;
    mem_wa     = base_r + ADDR_W'(n_r[IDX_W-1:0]);
    mem_wd     = pid_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt     = req.op;
          pid_nxt    = req.proc_id;
          lvl_nxt    = in_lvl;
          lvl_ok_nxt = in_lvl_ok;
          base_nxt   = ADDR_W'(in_lvl) * ADDR_W'(ENTRIES_PER_LEVEL);
          n_nxt      = in_lvl_ok ? occ_r[in_lvl] : '0;
          state_nxt  = S_START;
        end
      end

      S_START: begin
        rsp_nxt.result_id   = pid_r;
        rsp_nxt.status      = STAT_OK;
        rsp_nxt.level_count = LCOUNT_W'(n_r);
        state_nxt           = S_DONE;
        if (!lvl_ok_r) begin
          rsp_nxt.level_count = '0;
          case (op_r)
            OP_ENQ: rsp_nxt.status = STAT_FULL;
            OP_DEQ: begin
              rsp_nxt.status    = STAT_EMPTY;
              rsp_nxt.result_id = '0;
            end
            OP_REM: rsp_nxt.status = STAT_NOTFOUND;
            default: rsp_nxt.status = STAT_OK;
          endcase
        end else begin
          case (op_r)
            OP_ENQ: begin
              if (n_r >= CNT_W'(ENTRIES_PER_LEVEL)) begin
                rsp_nxt.status = STAT_FULL;
              end else begin
                mem_we              = 1'b1;
                n_nxt               = n_r + CNT_W'(1);
                occ_nxt[lvl_r]      = n_r + CNT_W'(1);
                rsp_nxt.level_count = LCOUNT_W'(n_r + CNT_W'(1));
              end
            end
            OP_DEQ: begin
              if (n_r == '0) begin
                rsp_nxt.status    = STAT_EMPTY;
                rsp_nxt.result_id = '0;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = base_r;
                state_nxt = S_HEAD;
              end
            end
            OP_REM: begin
              if (n_r == '0) begin
                rsp_nxt.status = STAT_NOTFOUND;
              end else begin
                ri_nxt    = '0;
                pv_nxt    = 1'b0;
                hit_nxt   = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            default: rsp_nxt.status = STAT_OK;
          endcase
        end
      end

      S_HEAD: begin
        // The head entry is out of the memory; the rest moves forward from index one.
        rsp_nxt.result_id = rd_q;
        pos_nxt           = '0;
        ri_nxt            = CNT_W'(1);
        pv_nxt            = 1'b0;
        state_nxt         = S_SHIFT;
      end

      S_SCAN: begin
        mem_re   = issue;
        pv_nxt   = issue;
        pidx_nxt = ri_r;
        if (issue) begin
          ri_nxt = ri_r + CNT_W'(1);
        end
        // Later matches overwrite earlier ones, so the hit nearest the tail wins.
        if (pv_r && (rd_q == pid_r)) begin
          hit_nxt = 1'b1;
          pos_nxt = pidx_r[IDX_W-1:0];
        end
        if (!issue && !pv_r) begin
          if (hit_r) begin
            ri_nxt    = CNT_W'(pos_r) + CNT_W'(1);
            pv_nxt    = 1'b0;
            state_nxt = S_SHIFT;
          end else begin
            rsp_nxt.status = STAT_NOTFOUND;
            state_nxt      = S_DONE;
          end
        end
      end

      S_SHIFT: begin
        mem_re   = issue;
        pv_nxt   = issue;
        pidx_nxt = ri_r;
        if (issue) begin
          ri_nxt = ri_r + CNT_W'(1);
        end
        // Each entry read last cycle is written back one place nearer the head.
        if (pv_r) begin
          mem_we = 1'b1;
          mem_wa = base_r + ADDR_W'(wr_idx[IDX_W-1:0]);
          mem_wd = rd_q;
        end
        if (!issue && !pv_r) begin
          n_nxt               = n_r - CNT_W'(1);
          occ_nxt[lvl_r]      = n_r - CNT_W'(1);
          rsp_nxt.level_count = LCOUNT_W'(n_r - CNT_W'(1));
          state_nxt           = S_DONE;
        end
      end

      S_DONE: begin
        if (rsp_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < LEVELS; i++) begin
        occ_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    pid_r    <= pid_nxt;
    lvl_r    <= lvl_nxt;
    lvl_ok_r <= lvl_ok_nxt;
    base_r   <= base_nxt;
    n_r      <= n_nxt;
    ri_r     <= ri_nxt;
    pv_r     <= pv_nxt;
    pidx_r   <= pidx_nxt;
    hit_r    <= hit_nxt;
    pos_r    <= pos_nxt;
    rsp_r    <= rsp_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

endmodule

// ===== rtl/multi_level_process_queue.sv =====
// Top level of the multi-level process queue: stream ports and output register.
// Five priority levels, each a FIFO of up to 64 six-bit process ids.
// Each input beat on in_* carries one operation: enqueue to the tail of a level,
// dequeue the head of a level, or remove a given id from a level.
// Each input beat produces exactly one output beat on out_* with the resulting id,
// a status code and the addressed level's occupancy after the operation.
// One operation is in flight at a time; in_tready is high only while idle.
// Dequeue and remove take longer than enqueue and grow with the level's occupancy:
// the entry memory has one read and one write port and is read one entry per
// cycle to search a level and to close the gap.
// The output beat sits in a register; the engine finishes the next operation
// while it waits and holds that result until the register frees up.
// Reset clears all occupancy counts, so every level starts empty; entry contents
// need no clearing because only occupied entries are ever read.
// When the receiver stalls, out_tdata holds and the block stops taking input once the engine holds a finished result.
module multi_level_process_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op[1:0], level_select[4:2], proc_id[10:5], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // result_id[5:0], status[7:6], level_count[14:8], zero pad
);
  import mlpq_pkg::*;

  req_t        req;
  rsp_t        eng_rsp;
  logic        eng_rsp_valid;
  logic        rsp_take;
  logic        out_valid_r;
  rsp_t        out_rsp_r;

  assign req.op           = in_tdata[1:0];
  assign req.level_select = in_tdata[4:2];
  assign req.proc_id      = in_tdata[10:5];

  assign rsp_take = !out_valid_r || out_tready;

  mlpq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (in_tready),
    .rsp_valid (eng_rsp_valid),
    .rsp       (eng_rsp),
    .rsp_take  (rsp_take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_rsp_valid && rsp_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_rsp_valid && rsp_take) begin
      out_rsp_r <= eng_rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_rsp_r};

endmodule
